// ----- src/ntoe_pkg.sv -----
// Shared types, constants and codes for the node table oldest-eviction unit.
package ntoe_pkg;

	localparam int NTOE_MAX_NODES = 16;
	localparam int ID_W           = 32;
	localparam int TIME_W         = 23;
	localparam int SLOT_W         = 4;
	localparam int COUNT_W        = 5;

	localparam logic [ID_W-1:0] ID_NONE     = '0;
	localparam logic [ID_W-1:0] ID_RESERVED = '1;

	typedef enum logic {
		CMD_SIGHTING  = 1'b0,
		CMD_TELEMETRY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_REJECTED  = 3'd0,
		OUT_REFRESHED = 3'd1,
		OUT_INSERTED  = 3'd2,
		OUT_EVICTED   = 3'd3,
		OUT_TELEMETRY = 3'd4,
		OUT_UNKNOWN   = 3'd5
	} outcome_t;

	// search word handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic              have_old;
		logic [TIME_W-1:0] old_time;
		logic [ID_W-1:0]   old_id;
	} srch_t;

	// write word broadcast to all cells
	typedef struct packed {
		logic              sight;
		logic              fresh;
		logic              tele;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] seen;
		logic signed [7:0] snr;
		logic signed [15:0] rssi;
		logic [7:0]        batt;
		logic [15:0]       volt;
	} wr_t;

endpackage

// ----- src/ntoe_cell.sv -----
// One table entry with its stage of the search chain.
module ntoe_cell import ntoe_pkg::*; #(
	parameter int MAX_NODES = NTOE_MAX_NODES,
	parameter int IDX       = 0,
	localparam int IDX_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
	localparam int CNT_W    = $clog2(MAX_NODES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  logic [ID_W-1:0]  id,
	input  srch_t            tok_in,
	input  logic [IDX_W-1:0] hit_idx_in,
	input  logic [IDX_W-1:0] old_idx_in,
	output srch_t            tok_out,
	output logic [IDX_W-1:0] hit_idx_out,
	output logic [IDX_W-1:0] old_idx_out,
	input  logic             wr_en,
	input  wr_t              wr
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] IDX_I = IDX_W'(IDX);

	logic [ID_W-1:0]    id_q;
	logic [TIME_W-1:0]  seen_q;
	logic signed [7:0]  snr_q;
	logic signed [15:0] rssi_q;
	logic [7:0]         batt_q;
	logic [15:0]        volt_q;
	logic               tel_q;

	logic  in_range, match, older;
	srch_t tok_nx;
	srch_t tok_q;
	logic [IDX_W-1:0] hit_idx_q, old_idx_q;

	always_comb begin
		in_range = IDX_C < count;
		match    = in_range && !tok_in.hit && (id_q == id);
		older    = in_range && !tok_in.hit && !match &&
			(!tok_in.have_old || (seen_q < tok_in.old_time));
		tok_nx = tok_in;
		if (match) begin
			tok_nx.hit = 1'b1;
		end
		if (older) begin
			tok_nx.have_old = 1'b1;
			tok_nx.old_time = seen_q;
			tok_nx.old_id   = id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q <= match ? IDX_I : hit_idx_in;
		old_idx_q <= older ? IDX_I : old_idx_in;
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr.sight) begin
				seen_q <= wr.seen;
				snr_q  <= wr.snr;
				rssi_q <= wr.rssi;
			end
			if (wr.fresh) begin
				id_q  <= wr.id;
				tel_q <= 1'b0;
			end
			if (wr.tele) begin
				batt_q <= wr.batt;
				volt_q <= wr.volt;
				tel_q  <= 1'b1;
			end
		end
	end

	assign tok_out     = tok_q;
	assign hit_idx_out = hit_idx_q;
	assign old_idx_out = old_idx_q;

endmodule

// ----- src/node_table_oldest_eviction_unit.sv -----
// Top level of the node table with oldest-timestamp eviction.
// One command word at a time: in_stall stays high from acceptance until the
// word commits. The search word is registered into tok0_q, walks the chain
// of MAX_NODES entry cells one cell per cycle, waits in fin_q, then commits.
// A stalled result holds back the next commit and so the next acceptance.
// Reset (arst_n low, asynchronous): table empty, chain and output idle.
module node_table_oldest_eviction_unit import ntoe_pkg::*; #(
	parameter int MAX_NODES = NTOE_MAX_NODES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [ID_W-1:0]      node_id,
	input  logic signed [7:0]    snr,
	input  logic signed [15:0]   rssi,
	input  logic [7:0]           batt_level,
	input  logic [15:0]          voltage_mv,
	input  logic [TIME_W-1:0]    time_seconds,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_W-1:0]    slot,
	output logic [2:0]           outcome,
	output logic [ID_W-1:0]      evicted_id,
	output logic [COUNT_W-1:0]   node_count
);

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_NODES);

	// held command word; busy_q keeps it stable until commit
	logic               busy_q;
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic signed [7:0]  snr_q;
	logic signed [15:0] rssi_q;
	logic [7:0]         batt_q;
	logic [15:0]        volt_q;
	logic [TIME_W-1:0]  time_q;
	logic [CNT_W-1:0]   count_q;

	logic accept, commit;

	// search chain: tok[i] feeds cell i, tok[MAX_NODES] leaves the last cell
	srch_t            tok [MAX_NODES+1];
	logic [IDX_W-1:0] hidx [MAX_NODES+1];
	logic [IDX_W-1:0] oidx [MAX_NODES+1];
	srch_t            tok0_q;

	// finished search, held until the output register is free
	srch_t            fin_q;
	logic [IDX_W-1:0] fin_hidx_q, fin_oidx_q;

	// commit decision
	wr_t              wr;
	logic             do_wr;
	logic             reserved;
	logic [IDX_W-1:0] tgt;
	outcome_t         res_outcome;
	logic [ID_W-1:0]  res_evict;
	logic [CNT_W-1:0] count_nx;
	logic [MAX_NODES-1:0] wr_en;

	// output register
	logic               out_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	outcome_t           outcome_q;
	logic [ID_W-1:0]    evict_q;
	logic [COUNT_W-1:0] count_out_q;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign commit   = fin_q.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			id_q   <= node_id;
			snr_q  <= snr;
			rssi_q <= rssi;
			batt_q <= batt_level;
			volt_q <= voltage_mv;
			time_q <= time_seconds;
		end
	end

	// launch a fresh search word in the cycle after acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q <= '{valid: accept, default: '0};
		end
	end

	assign tok[0]  = tok0_q;
	assign hidx[0] = '0;
	assign oidx[0] = '0;

	for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
		assign wr_en[g] = commit && do_wr && (tgt == IDX_W'(g));

		ntoe_cell #(
			.MAX_NODES (MAX_NODES),
			.IDX       (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.count       (count_q),
			.id          (id_q),
			.tok_in      (tok[g]),
			.hit_idx_in  (hidx[g]),
			.old_idx_in  (oidx[g]),
			.tok_out     (tok[g+1]),
			.hit_idx_out (hidx[g+1]),
			.old_idx_out (oidx[g+1]),
			.wr_en       (wr_en[g]),
			.wr          (wr)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0;
		end else if (tok[MAX_NODES].valid) begin
			fin_q <= tok[MAX_NODES];
		end else if (commit) begin
			fin_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_NODES].valid) begin
			fin_hidx_q <= hidx[MAX_NODES];
			fin_oidx_q <= oidx[MAX_NODES];
		end
	end

	// Sightings reject id zero and all-ones; telemetry rejects only zero.
	// A sighting miss appends while there is room, else replaces the oldest.
	always_comb begin
		reserved = (id_q == ID_NONE) ||
			((cmd_q == CMD_SIGHTING) && (id_q == ID_RESERVED));
		res_outcome = OUT_REJECTED;
		res_evict   = '0;
		tgt         = '0;
		do_wr       = 1'b0;
		count_nx    = count_q;
		wr.sight    = 1'b0;
		wr.fresh    = 1'b0;
		wr.tele     = 1'b0;
		wr.id       = id_q;
		wr.seen     = time_q;
		wr.snr      = snr_q;
		wr.rssi     = rssi_q;
		wr.batt     = batt_q;
		wr.volt     = volt_q;
		if (!reserved) begin
			unique case (cmd_q)
				CMD_SIGHTING: begin
					do_wr    = 1'b1;
					wr.sight = 1'b1;
					priority if (fin_q.hit) begin
						res_outcome = OUT_REFRESHED;
						tgt         = fin_hidx_q;
					end else if (count_q != FULL) begin
						res_outcome = OUT_INSERTED;
						tgt         = IDX_W'(count_q);
						wr.fresh    = 1'b1;
						count_nx    = CNT_W'(count_q + 1'b1);
					end else begin
						res_outcome = OUT_EVICTED;
						tgt         = fin_oidx_q;
						res_evict   = fin_q.old_id;
						wr.fresh    = 1'b1;
					end
				end
				CMD_TELEMETRY: begin
					if (fin_q.hit) begin
						res_outcome = OUT_TELEMETRY;
						tgt         = fin_hidx_q;
						do_wr       = 1'b1;
						wr.tele     = 1'b1;
					end else begin
						res_outcome = OUT_UNKNOWN;
					end
				end
				default: begin
					res_outcome = OUT_REJECTED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			slot_q      <= SLOT_W'(tgt);
			outcome_q   <= res_outcome;
			evict_q     <= res_evict;
			count_out_q <= COUNT_W'(count_nx);
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign outcome    = outcome_q;
	assign evicted_id = evict_q;
	assign node_count = count_out_q;

endmodule

// ----- src/ntoe_checker.sv -----
// Port-level assertions for the node table unit, bound to the top level.
module ntoe_checker import ntoe_pkg::*; #(
	parameter int MAX_NODES = NTOE_MAX_NODES
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [SLOT_W-1:0]  slot,
	input logic [2:0]         outcome,
	input logic [ID_W-1:0]    evicted_id,
	input logic [COUNT_W-1:0] node_count
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(slot)
			&& $stable(evicted_id) && $stable(node_count))
		else $error("result word changed while stalled");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome <= OUT_UNKNOWN))
		else $error("outcome code out of range");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((outcome == OUT_REJECTED) || (outcome == OUT_UNKNOWN))
			|-> (slot == '0) && (evicted_id == '0))
		else $error("rejected or unknown word touches a slot");

	a_evict_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != OUT_EVICTED) |-> (evicted_id == '0))
		else $error("evicted id without eviction");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((outcome == OUT_EVICTED) || (outcome == OUT_INSERTED))
			|-> ({27'd0, node_count} <= 32'(MAX_NODES)) && (node_count != '0))
		else $error("table count inconsistent with outcome");

endmodule

bind node_table_oldest_eviction_unit ntoe_checker #(.MAX_NODES(MAX_NODES)) u_ntoe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.slot       (slot),
	.outcome    (outcome),
	.evicted_id (evicted_id),
	.node_count (node_count)
);
